/* rtl/core/lhbe_pkg.sv */
// Shared constants, register codes and unit interface types for the LED heartbeat envelope.
`default_nettype none

package lhbe_pkg;

    // Field and state widths
    localparam int TIME_BITS   = 32;
    localparam int LEVEL_BITS  = 8;
    localparam int BPM_BITS    = 9;
    localparam int RAMP_BITS   = 16;
    localparam int QUOT_BITS   = 16;
    localparam int STEP_BITS   = 12;
    localparam int CFG_BITS    = 16;

    // Elapsed time is capped at 2^ELAP_CAP_LOG ms
    localparam int ELAP_CAP_LOG = 24;
    localparam int ELAP_BITS    = ELAP_CAP_LOG + 1;

    // Widest dividend: step base times capped elapsed time plus rounding bias
    localparam int PROD_BITS    = 36;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
    localparam int MUL_CNT_BITS = $clog2(STEP_BITS + 1);

    // Rate arithmetic: period = (RATE_NUM + b) / (2b), third = (2p + 3) / 6
    localparam int RATE_NUM      = 120000;
    localparam int THIRD_BIAS    = 3;
    localparam int THIRD_DIVISOR = 6;
    localparam int STEP_DIVISOR  = 20;

    // Reset values
    localparam int RISE_RESET   = 100;
    localparam int FADE_RESET   = 500;
    localparam int PERIOD_RESET = 1000;
    localparam int THIRD_RESET  = 333;
    localparam int STEP_RESET   = 50;
    localparam int LEVEL_MAX    = 255;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BPM  = 2'd0,
        REG_RISE = 2'd1,
        REG_FADE = 2'd2,
        REG_NONE = 2'd3
    } cfg_reg_t;

    // Serial divider request and response
    typedef struct packed {
        logic                 start;
        logic [PROD_BITS-1:0] dividend;
        logic [RAMP_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic                 overflow;
        logic [QUOT_BITS-1:0] quotient;
    } div_rsp_t;

    // Serial multiplier request and response
    typedef struct packed {
        logic                 start;
        logic [ELAP_BITS-1:0] multiplicand;
        logic [STEP_BITS-1:0] multiplier;
    } mul_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [PROD_BITS-1:0] product;
    } mul_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/lhbe_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, sticky quotient overflow.
`default_nettype none

module lhbe_div
    import lhbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]    dsr_reg;
    logic [RAMP_BITS-1:0]    dvs_reg;
    logic [RAMP_BITS-1:0]    rem_reg;
    logic [QUOT_BITS-1:0]    quo_reg;
    logic                    ovf_reg;

    logic [RAMP_BITS:0]      trial;
    logic [RAMP_BITS:0]      diff;
    logic                    fits;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, dsr_reg[PROD_BITS-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // Count the iterations
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(PROD_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the dividend, remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dsr_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            dsr_reg <= {dsr_reg[PROD_BITS-2:0], 1'b0};
            rem_reg <= fits ? diff[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];
            quo_reg <= {quo_reg[QUOT_BITS-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[QUOT_BITS-1];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.overflow = ovf_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/lhbe_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
`default_nettype none

module lhbe_mul
    import lhbe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MUL_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [ELAP_BITS-1:0]    mcand_reg;
    logic [ELAP_BITS-1:0]    hi_reg;
    logic [STEP_BITS-1:0]    lo_reg;

    logic [ELAP_BITS:0]           sum;
    logic [ELAP_BITS+STEP_BITS-1:0] full;

    // Add the multiplicand when the current multiplier bit is set
    always_comb
    begin
        sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        full = {hi_reg, lo_reg};
    end

    // Count the iterations
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = MUL_CNT_BITS'(STEP_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - MUL_CNT_BITS'(1);
            if (cnt_reg == MUL_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift the partial product right, multiplier bits drop out at the bottom
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg <= req.multiplicand;
            hi_reg    <= '0;
            lo_reg    <= req.multiplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[ELAP_BITS:1];
            lo_reg <= {sum[0], lo_reg[STEP_BITS-1:1]};
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = full[PROD_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/core/led_heartbeat_envelope_unit.sv */
// Top level of the double-pulse LED heartbeat envelope generator.
//
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  now_ms[31:0]
//  output    out        out_valid/out_stall brightness[7:0]
//  config    in         cfg_valid/cfg_ready cfg_index[1:0], cfg_data[15:0]
//
// From acceptance to result, one word runs a serial multiply of the step
// base by the elapsed time, then a serial divide by the ramp time. A rate
// write runs three serial divides in turn (period, third of period, step
// base), with cfg_ready low throughout.
// Reset restores 60 bpm timing, 100/500 ms ramps and a dark, falling LED.
// A finished word waits in the output register; a stalled output holds only
// the final update of the next word.
`default_nettype none

module led_heartbeat_envelope_unit
    import lhbe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [TIME_BITS-1:0]  now_ms,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [LEVEL_BITS-1:0]      brightness,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_BITS-1:0]   cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CFG_P = 8'b0000_0010,
        S_CFG_T = 8'b0000_0100,
        S_CFG_Q = 8'b0000_1000,
        S_DIFF  = 8'b0001_0000,
        S_MUL   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;

    // Architectural state
    logic [LEVEL_BITS-1:0]  level_reg;
    logic                   rising_reg;
    logic                   second_reg;
    logic [TIME_BITS-1:0]   last_upd_reg;
    logic [TIME_BITS-1:0]   last_beat_reg;
    logic [QUOT_BITS-1:0]   period_reg;
    logic [QUOT_BITS-1:0]   third_reg;
    logic [STEP_BITS-1:0]   step_base_reg;
    logic [RAMP_BITS-1:0]   rise_reg;
    logic [RAMP_BITS-1:0]   fade_reg;
    logic                   out_valid_reg, out_valid_next;

    // Per-word working registers
    logic [TIME_BITS-1:0]   now_reg;
    logic [RAMP_BITS-1:0]   ramp_reg;
    logic                   third_hit_reg;
    logic                   period_hit_reg;
    logic [LEVEL_BITS-1:0]  brightness_reg;

    div_req_t               div_req;
    div_rsp_t               div_rsp;
    mul_req_t               mul_req;
    mul_rsp_t               mul_rsp;

    logic                   in_accept;
    logic                   bpm_write;
    logic                   finish_ok;
    logic [BPM_BITS-1:0]    bpm_eff;
    logic [TIME_BITS-1:0]   elapsed;
    logic [TIME_BITS-1:0]   since_beat;
    logic [ELAP_BITS-1:0]   elapsed_cap;
    logic [RAMP_BITS-1:0]   ramp_sel;

    logic                   step_big;
    logic [LEVEL_BITS-1:0]  step8;
    logic [LEVEL_BITS:0]    level_sum;
    logic [LEVEL_BITS-1:0]  level_new;
    logic                   rising_new;
    logic                   second_new;

    lhbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lhbe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Handshakes
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign in_accept = in_valid && !in_stall;
    assign bpm_write = cfg_valid && cfg_ready && (cfg_index == REG_BPM);
    assign finish_ok = !out_valid_reg || !out_stall;

    // Rate of zero counts as one
    assign bpm_eff = (cfg_data[BPM_BITS-1:0] == '0) ? BPM_BITS'(1) : cfg_data[BPM_BITS-1:0];

    // Time differences and the elapsed-time cap
    always_comb
    begin
        elapsed    = now_reg - last_upd_reg;
        since_beat = now_reg - last_beat_reg;
        if ((elapsed >> ELAP_CAP_LOG) != '0)
        begin
            elapsed_cap = ELAP_BITS'(1) << ELAP_CAP_LOG;
        end
        else
        begin
            elapsed_cap = elapsed[ELAP_BITS-1:0];
        end
        ramp_sel = rising_reg ? rise_reg : fade_reg;
        if (ramp_sel == '0)
        begin
            ramp_sel = RAMP_BITS'(1);
        end
    end

    // Sequence the shared divider and the multiplier
    always_comb
    begin
        state_next           = state_reg;
        div_req.start        = 1'b0;
        div_req.dividend     = '0;
        div_req.divisor      = RAMP_BITS'(1);
        mul_req.start        = 1'b0;
        mul_req.multiplicand = elapsed_cap;
        mul_req.multiplier   = step_base_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (bpm_write)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = PROD_BITS'(RATE_NUM) + PROD_BITS'(bpm_eff);
                    div_req.divisor  = RAMP_BITS'({bpm_eff, 1'b0});
                    state_next       = S_CFG_P;
                end
                else if (in_accept)
                begin
                    state_next = S_DIFF;
                end
            end
            S_CFG_P:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = PROD_BITS'({div_rsp.quotient, 1'b0})
                                     + PROD_BITS'(THIRD_BIAS);
                    div_req.divisor  = RAMP_BITS'(THIRD_DIVISOR);
                    state_next       = S_CFG_T;
                end
            end
            S_CFG_T:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = PROD_BITS'(period_reg);
                    div_req.divisor  = RAMP_BITS'(STEP_DIVISOR);
                    state_next       = S_CFG_Q;
                end
            end
            S_CFG_Q:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIFF:
            begin
                mul_req.start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_rsp.product
                                     + PROD_BITS'(ramp_reg - RAMP_BITS'(1));
                    div_req.divisor  = ramp_reg;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Apply the step, then the beat triggers
    always_comb
    begin
        step_big  = div_rsp.overflow || (div_rsp.quotient[QUOT_BITS-1:LEVEL_BITS] != '0);
        step8     = div_rsp.quotient[LEVEL_BITS-1:0];
        level_sum = {1'b0, level_reg} + {1'b0, step8};
        if (rising_reg)
        begin
            if (step_big || level_sum[LEVEL_BITS])
            begin
                level_new  = LEVEL_BITS'(LEVEL_MAX);
                rising_new = 1'b0;
            end
            else
            begin
                level_new  = level_sum[LEVEL_BITS-1:0];
                rising_new = 1'b1;
            end
        end
        else
        begin
            rising_new = 1'b0;
            if (step_big || (step8 >= level_reg))
            begin
                level_new = '0;
            end
            else
            begin
                level_new = level_reg - step8;
            end
        end
        second_new = second_reg;
        if (!second_reg && third_hit_reg)
        begin
            second_new = 1'b1;
            rising_new = 1'b1;
        end
        if (period_hit_reg)
        begin
            second_new = 1'b0;
            rising_new = 1'b1;
        end
    end

    assign out_valid_next = (out_valid_reg && out_stall) || ((state_reg == S_DONE) && finish_ok);

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            rising_reg    <= 1'b0;
            second_reg    <= 1'b0;
            last_upd_reg  <= '0;
            last_beat_reg <= '0;
            period_reg    <= QUOT_BITS'(PERIOD_RESET);
            third_reg     <= QUOT_BITS'(THIRD_RESET);
            step_base_reg <= STEP_BITS'(STEP_RESET);
            rise_reg      <= RAMP_BITS'(RISE_RESET);
            fade_reg      <= RAMP_BITS'(FADE_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            // Hold ramp registers until written
            if (cfg_valid && cfg_ready && (cfg_index == REG_RISE))
            begin
                rise_reg <= cfg_data[RAMP_BITS-1:0];
            end
            if (cfg_valid && cfg_ready && (cfg_index == REG_FADE))
            begin
                fade_reg <= cfg_data[RAMP_BITS-1:0];
            end
            // Store the rate results as each divide ends
            if ((state_reg == S_CFG_P) && div_rsp.done)
            begin
                period_reg <= div_rsp.quotient;
            end
            if ((state_reg == S_CFG_T) && div_rsp.done)
            begin
                third_reg <= div_rsp.quotient;
            end
            if ((state_reg == S_CFG_Q) && div_rsp.done)
            begin
                step_base_reg <= div_rsp.quotient[STEP_BITS-1:0];
            end
            // Commit the envelope update with the result word
            if ((state_reg == S_DONE) && finish_ok)
            begin
                level_reg    <= level_new;
                rising_reg   <= rising_new;
                second_reg   <= second_new;
                last_upd_reg <= now_reg;
                if (period_hit_reg)
                begin
                    last_beat_reg <= now_reg;
                end
            end
        end
    end

    // Per-word payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg <= now_ms;
        end
        if (state_reg == S_DIFF)
        begin
            ramp_reg       <= ramp_sel;
            third_hit_reg  <= (since_beat > TIME_BITS'(third_reg));
            period_hit_reg <= (since_beat > TIME_BITS'(period_reg));
        end
        if ((state_reg == S_DONE) && finish_ok)
        begin
            brightness_reg <= level_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign brightness = brightness_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_DIFF))
        else $error("accepted word did not start the time differences");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_rsp.busy && div_rsp.busy))
        else $error("multiplier and divider busy together");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the final update");

    assert property (@(posedge clk) disable iff (!rst_n)
        bpm_write |=> ((state_reg == S_CFG_P) && !cfg_ready))
        else $error("rate write did not start the period divide");

endmodule

`default_nettype wire
